@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/tsw_pkg.sv @@
// Package: constants, types and helper functions of the texture sampler
package tsw_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int CoordFracBits = 16;
  localparam int WeightFracBits = 8;
  localparam int XBits = $clog2(MaxWidth);
  localparam int YBits = $clog2(MaxHeight);
  localparam int AddrBits = XBits + YBits;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int SizeBits = 9;
  localparam int WBits = WeightFracBits + 1;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_NEAREST = 2'd1,
    FUNC_BILIN   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // expand one RGB565 texel into three 8-bit channels (r, g, b)
  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction
endpackage

@@ design/tsw_ram.sv @@
// Generic single-port RAM with registered read
module tsw_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/tsw_axis.sv @@
// Per-axis coordinate wrap: nearest index, bilinear indices and weight (registered)
module tsw_axis (
  input  logic                          clk,
  input  logic                          load,
  input  logic [31:0]                   coord,
  input  logic [tsw_pkg::SizeBits-1:0]  size,
  output logic [tsw_pkg::SizeBits-1:0]  near_idx,
  output logic [tsw_pkg::SizeBits-1:0]  i0,
  output logic [tsw_pkg::SizeBits-1:0]  i1,
  output logic [tsw_pkg::WBits-1:0]     wt
);
  import tsw_pkg::*;

  localparam int ProdBits = CoordFracBits + SizeBits + 1;

  logic [ProdBits-1:0]       prod, t;
  logic [SizeBits:0]         ip;
  logic [SizeBits-1:0]       i0_c, i1_c;
  logic [SizeBits-1:0]       near_r, i0_r, i1_r, near_nxt, i0_nxt, i1_nxt;
  logic [WBits-1:0]          wt_r, wt_nxt;

  always_comb begin
    prod = ProdBits'(coord[CoordFracBits-1:0]) * ProdBits'(size);
    near_nxt = prod[CoordFracBits +: SizeBits];
    t = prod + ProdBits'(1 << (CoordFracBits - 1));
    ip = t[CoordFracBits +: SizeBits+1];
    // ip is in 0..size: ip==0 wraps to size-1
    i0_c = (ip == '0) ? size - SizeBits'(1) : ip[SizeBits-1:0] - SizeBits'(1);
    i1_c = (i0_c + SizeBits'(1) == size) ? '0 : i0_c + SizeBits'(1);
    i0_nxt = i0_c;
    i1_nxt = i1_c;
    wt_nxt = {1'b0, t[CoordFracBits-1 -: WeightFracBits]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      near_r <= near_nxt;
      i0_r   <= i0_nxt;
      i1_r   <= i1_nxt;
      wt_r   <= wt_nxt;
    end
  end

  assign near_idx = near_r;
  assign i0 = i0_r;
  assign i1 = i1_r;
  assign wt = wt_r;
endmodule

@@ design/tsw_blend.sv @@
// Bilinear blend accumulator: adds one weighted texel per cycle while acc_en is high, then repacks
module tsw_blend (
  input  logic                      clk,
  input  logic                      clear,
  input  logic                      acc_en,
  input  logic [15:0]               texel,
  input  logic [2*tsw_pkg::WBits-1:0] weight,
  output logic [15:0]               color
);
  import tsw_pkg::*;

  localparam int AccBits = 8 + 2 * WBits;

  logic [23:0]        ch;
  logic [AccBits-1:0] acc_r [3];
  logic [AccBits-1:0] acc_nxt [3];
  logic [7:0]         res [3];

  always_comb begin
    ch = expand565(texel);
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = (clear ? '0 : acc_r[k]) +
                   AccBits'(ch[23-8*k -: 8]) * AccBits'(weight);
      res[k] = acc_r[k][2*WeightFracBits +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= acc_nxt[k];
      end
    end
  end

  assign color = {res[0][7:3], res[1][7:2], res[2][7:3]};
endmodule

@@ design/tsw_clear.sv @@
// Post-reset clearing sweep of the texel store
module tsw_clear (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        active,
  output logic [tsw_pkg::AddrBits-1:0] addr
);
  import tsw_pkg::*;

  logic [AddrBits-1:0] addr_r, addr_nxt;
  logic                act_r, act_nxt;

  always_comb begin
    addr_nxt = addr_r + AddrBits'(1);
    act_nxt  = act_r && (addr_r != AddrBits'(StoreDepth - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      act_r  <= 1'b1;
    end else if (act_r) begin
      addr_r <= addr_nxt;
      act_r  <= act_nxt;
    end
  end

  assign active = act_r;
  assign addr = addr_r;
endmodule

@@ design/texture_sampler_wrap_bilinear.sv @@
// Top level of the wrapping RGB565 texture sampler
// Texture sampler with a 256x256 RGB565 store (one synchronous single-port RAM,
// texel address = row * width + column). After reset busy stays high while the
// store is swept to black; configuration writes are taken throughout. start is
// taken when busy is low. A texel write runs ST_AXIS, a nearest sample ST_AXIS,
// ST_RD0, ST_ACC and ST_OUT, a bilinear sample ST_AXIS, ST_RD0 to ST_RD3, ST_ACC
// and ST_OUT, before the next start: the single RAM port reads the four bilinear
// texels one per cycle and the blend unit adds one weighted texel per cycle. Each
// sample result appears on out_sample_color for one cycle with out_valid high;
// the receiver cannot stall it. Writes outside width/height and func 3 give no
// result. Width/height values of 0 act as 1 and values above 256 as 256.
module texture_sampler_wrap_bilinear (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_write_x,
  input  logic [15:0] in_write_y,
  input  logic [15:0] in_write_color,
  input  logic [31:0] in_coord_u,
  input  logic [31:0] in_coord_v,
  output logic        out_valid,
  output logic [15:0] out_sample_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import tsw_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_AXIS, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_ACC, ST_OUT
  } state_t;

  state_t              state_r;
  logic                bil_r;
  logic [SizeBits-1:0] width_r, height_r, w_eff, h_eff;
  logic [15:0]         wx_r, wy_r, wcol_r;
  logic [31:0]         u_r, v_r;
  logic [1:0]          rd_cnt_r;
  logic                acc_pend_r;
  logic [1:0]          acc_sel_r;
  logic                out_valid_r;
  logic [15:0]         out_col_r;

  logic                clr_active;
  logic [AddrBits-1:0] clr_addr;
  logic [SizeBits-1:0] xn, yn, x0, x1, y0, y1;
  logic [WBits-1:0]    wtx, wty;
  logic                ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [15:0]         ram_wdata, ram_rdata;
  logic [SizeBits-1:0] rx, ry;
  logic [2*SizeBits-1:0] lin;
  logic [WBits-1:0]    fx, fy;
  logic [2*WBits-1:0]  weight;
  logic [15:0]         blend_col;
  logic                load;
  logic                wr_ok;

  // effective sizes: 0 acts as 1, above max clamps
  always_comb begin
    w_eff = (width_r == '0) ? SizeBits'(1) :
            (width_r > SizeBits'(MaxWidth)) ? SizeBits'(MaxWidth) : width_r;
    h_eff = (height_r == '0) ? SizeBits'(1) :
            (height_r > SizeBits'(MaxHeight)) ? SizeBits'(MaxHeight) : height_r;
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SizeBits'(MaxWidth);
      height_r <= SizeBits'(MaxHeight);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tsw_clear u_clear (.clk, .rst_n, .active(clr_active), .addr(clr_addr));

  assign load = (state_r == ST_IDLE) && start && !clr_active;

  always_ff @(posedge clk) begin
    if (load) begin
      u_r <= in_coord_u;
      v_r <= in_coord_v;
      wx_r <= in_write_x;
      wy_r <= in_write_y;
      wcol_r <= in_write_color;
    end
  end

  tsw_axis u_ax (.clk, .load(state_r == ST_AXIS), .coord(u_r), .size(w_eff),
                 .near_idx(xn), .i0(x0), .i1(x1), .wt(wtx));
  tsw_axis u_ay (.clk, .load(state_r == ST_AXIS), .coord(v_r), .size(h_eff),
                 .near_idx(yn), .i0(y0), .i1(y1), .wt(wty));

  // address choice: texel k of the bilinear quad, k = {dy, dx}; write position in ST_AXIS
  always_comb begin
    rx = bil_r ? (rd_cnt_r[0] ? x1 : x0) : xn;
    ry = bil_r ? (rd_cnt_r[1] ? y1 : y0) : yn;
    if (state_r == ST_AXIS) begin
      rx = wx_r[SizeBits-1:0];
      ry = wy_r[SizeBits-1:0];
    end
    lin = ry * w_eff + (2*SizeBits)'(rx);
  end

  assign wr_ok = (wx_r < 16'(w_eff)) && (wy_r < 16'(h_eff));

  always_comb begin
    ram_we = 1'b0;
    ram_addr = lin[AddrBits-1:0];
    ram_wdata = wcol_r;
    if (clr_active) begin
      ram_we = 1'b1;
      ram_addr = clr_addr;
      ram_wdata = '0;
    end else if (state_r == ST_AXIS && !bil_r && rd_cnt_r == 2'd3) begin
      ram_we = wr_ok;
    end
  end

  tsw_ram #(.Width(16), .Depth(StoreDepth)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));

  // weights; nearest uses full weight on one texel
  always_comb begin
    fx = acc_sel_r[0] ? wtx : WBits'(1 << WeightFracBits) - wtx;
    fy = acc_sel_r[1] ? wty : WBits'(1 << WeightFracBits) - wty;
    weight = bil_r ? fx * fy : (2*WBits)'(1 << (2*WeightFracBits));
  end

  tsw_blend u_blend (.clk, .clear(acc_sel_r == 2'd0), .acc_en(acc_pend_r),
                     .texel(ram_rdata), .weight(weight), .color(blend_col));

  // sequencer; rd_cnt_r==3 in ST_AXIS marks a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bil_r <= 1'b0;
      rd_cnt_r <= '0;
      acc_pend_r <= 1'b0;
      acc_sel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      acc_pend_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (load) begin
          bil_r <= (in_func == FUNC_BILIN);
          rd_cnt_r <= (in_func == FUNC_WRITE) ? 2'd3 : 2'd0;
          if (in_func != FUNC_NONE) state_r <= ST_AXIS;
        end
        ST_AXIS: state_r <= (!bil_r && rd_cnt_r == 2'd3) ? ST_IDLE : ST_RD0;
        ST_RD0, ST_RD1, ST_RD2, ST_RD3: begin
          acc_pend_r <= 1'b1;
          acc_sel_r <= rd_cnt_r;
          rd_cnt_r <= rd_cnt_r + 2'd1;
          if (!bil_r || state_r == ST_RD3) state_r <= ST_ACC;
          else state_r <= state_t'(state_r + 3'd1);
        end
        ST_ACC: state_r <= ST_OUT;
        ST_OUT: begin
          out_valid_r <= 1'b1;
          out_col_r <= blend_col;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = clr_active || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_color = out_col_r;

  `ASSERT_IMPL(a_no_start_in_clear, clr_active, busy)
  `ASSERT_NEXT(a_out_single, out_valid, !out_valid)
  `ASSERT_IMPL(a_no_write_in_sample, ram_we && !clr_active, state_r == ST_AXIS)
endmodule

@@ bench/texture_sampler_wrap_bilinear_test.sv @@
// Self-checking testbench for the wrapping RGB565 texture sampler
module texture_sampler_wrap_bilinear_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsw_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [15:0] wx;
    logic [15:0] wy;
    logic [15:0] colour;
    logic [31:0] u;
    logic [31:0] v;
  } tex_req_t;

  // one entry per transaction on the sender side; a pause marker waits for drain,
  // a config marker writes a size register once everything is idle
  typedef struct packed {
    logic [1:0]  kind;   // 0 request, 1 drain pause, 2 config write
    tex_req_t    req;
    cfg_idx_t    idx;
    logic [8:0]  data;
  } pend_t;

  localparam logic [1:0] K_REQ = 2'd0;
  localparam logic [1:0] K_DRAIN = 2'd1;
  localparam logic [1:0] K_CFG = 2'd2;
  localparam int unsigned LIMIT = 400000;
  localparam int unsigned SETTLE = 20;

  logic clk, rst_n;
  logic start, busy, out_valid, cfg_valid, cfg_ready;
  logic [1:0] in_func;
  logic [15:0] in_write_x, in_write_y, in_write_color, out_sample_color;
  logic [31:0] in_coord_u, in_coord_v;
  logic [0:0] cfg_index;
  logic [8:0] cfg_data;

  texture_sampler_wrap_bilinear u_top (
    .clk, .rst_n, .start, .busy, .in_func, .in_write_x, .in_write_y,
    .in_write_color, .in_coord_u, .in_coord_v, .out_valid, .out_sample_color,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predictor state: its own copy of the store and the size registers
  logic [15:0] texels [StoreDepth];
  logic [8:0]  width_reg, height_reg;
  logic [15:0] colour_q[$];
  pend_t       pending_q[$];
  int unsigned errors, cycles;
  bit          idle_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [8:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return r;
  endfunction

  function automatic logic [15:0] fetch(int unsigned x, int unsigned y, int unsigned w);
    int unsigned a;
    a = y * w + x;
    return (a < StoreDepth) ? texels[a] : 16'h0;
  endfunction

  // bilinear axis: coordinates for the two taps and the weight of the second
  task automatic axis_taps(input logic [31:0] raw, input int unsigned size,
                           output int unsigned i0, output int unsigned i1,
                           output int unsigned wt);
    longint unsigned t;
    t = longint'(raw[15:0]) * size + 64'd32768;
    i0 = ((t >> 16) + size - 1) % size;
    i1 = (i0 + 1) % size;
    wt = (t & 64'hFFFF) >> 8;
  endtask

  function automatic logic [7:0] chan(logic [15:0] c, int k);
    case (k)
      0: chan = {c[15:11], c[15:13]};
      1: chan = {c[10:5], c[10:9]};
      default: chan = {c[4:0], c[4:2]};
    endcase
  endfunction

  // applies one accepted transaction to the predictor
  task automatic predict_sample(input tex_req_t r);
    int unsigned w, h, x0, x1, y0, y1, wx, wy, k;
    logic [15:0] t00, t10, t01, t11;
    longint unsigned s;
    logic [7:0] res [3];
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    case (r.func)
      FUNC_WRITE: begin
        if (r.wx < w && r.wy < h && r.wy * w + r.wx < StoreDepth)
          texels[r.wy * w + r.wx] = r.colour;
      end
      FUNC_NEAREST: begin
        x0 = (int'(r.u[15:0]) * w) >> 16;
        y0 = (int'(r.v[15:0]) * h) >> 16;
        colour_q.push_back(fetch(x0, y0, w));
      end
      FUNC_BILIN: begin
        axis_taps(r.u, w, x0, x1, wx);
        axis_taps(r.v, h, y0, y1, wy);
        t00 = fetch(x0, y0, w);
        t10 = fetch(x1, y0, w);
        t01 = fetch(x0, y1, w);
        t11 = fetch(x1, y1, w);
        for (k = 0; k < 3; k++) begin
          s = chan(t00, k) * (256 - wx) * (256 - wy) + chan(t10, k) * wx * (256 - wy)
            + chan(t01, k) * (256 - wx) * wy + chan(t11, k) * wx * wy;
          res[k] = s >> 16;
        end
        colour_q.push_back({res[0][7:3], res[1][7:2], res[2][7:3]});
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} - ($urandom_range(0, 1) << 31);
      2: return {16'($urandom_range(0, 3) - 2), 16'($urandom())};
      default: return {16'($urandom()), 16'($urandom_range(0, 1) ? 16'h8000 : 16'h0)};
    endcase
  endfunction

  task automatic add_req(func_t f, logic [15:0] x, logic [15:0] y, logic [15:0] c,
                         logic [31:0] u, logic [31:0] v);
    pend_t p;
    p = '0;
    p.kind = K_REQ;
    p.req = '{f, x, y, c, u, v};
    pending_q.push_back(p);
  endtask

  task automatic add_cfg(cfg_idx_t i, logic [8:0] d);
    pend_t p;
    p = '0;
    p.kind = K_CFG;
    p.idx = i;
    p.data = d;
    pending_q.push_back(p);
  endtask

  task automatic add_drain();
    pend_t p;
    p = '0;
    p.kind = K_DRAIN;
    pending_q.push_back(p);
  endtask

  // a phase: set both sizes, then a random mix of writes, samples and some noise, then a drain
  task automatic add_phase(int unsigned n, logic [8:0] wr, logic [8:0] hr);
    int unsigned i, w, h;
    w = eff_size(wr);
    h = eff_size(hr);
    add_cfg(CFG_WIDTH, wr);
    add_cfg(CFG_HEIGHT, hr);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_req(FUNC_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                         $urandom(), rand_coord(), rand_coord());
        3: add_req(FUNC_WRITE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        4, 5, 6: add_req(FUNC_BILIN, $urandom(), $urandom(), $urandom(),
                         rand_coord(), rand_coord());
        7, 8: add_req(FUNC_NEAREST, $urandom(), $urandom(), $urandom(),
                      rand_coord(), rand_coord());
        default: add_req(func_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
      endcase
    end
    add_drain();
  endtask

  // stimulus: directed corners first, then random phases over several sizes
  initial begin
    add_req(FUNC_WRITE, 0, 0, 16'hFFFF, 0, 0);
    add_req(FUNC_WRITE, 255, 255, 16'hF81F, 0, 0);
    add_req(FUNC_WRITE, 256, 0, 16'h1234, 0, 0);       // column out of range
    add_req(FUNC_WRITE, 0, 16'hFFFF, 16'h4321, 0, 0);  // row out of range
    add_req(FUNC_WRITE, 1, 0, 16'h07E0, 0, 0);
    add_req(FUNC_WRITE, 0, 1, 16'h001F, 0, 0);
    add_req(FUNC_NEAREST, 0, 0, 0, 32'h0, 32'h0);
    add_req(FUNC_NEAREST, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FUNC_NEAREST, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(FUNC_BILIN, 0, 0, 0, 32'h0, 32'h0);
    add_req(FUNC_BILIN, 0, 0, 0, 32'h0000_0080, 32'h0000_0080);
    add_req(FUNC_BILIN, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(FUNC_BILIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF80, 32'h0001_0000);
    add_req(FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_drain();
    // size 0 acts as 1, oversize as the maximum; texels then read under new row length
    add_cfg(CFG_WIDTH, 9'd0);
    add_cfg(CFG_HEIGHT, 9'd511);
    add_req(FUNC_BILIN, 0, 0, 0, 32'h1234_5678, 32'h0000_4000);
    add_req(FUNC_NEAREST, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0200);
    add_req(FUNC_WRITE, 0, 3, 16'hABCD, 0, 0);
    add_req(FUNC_WRITE, 1, 3, 16'hDCBA, 0, 0);
    add_drain();
    add_phase(200, 9'd4, 9'd4);
    add_phase(150, 9'd1, 9'd1);
    add_phase(150, 9'd256, 9'd256);
    add_phase(150, 9'd3, 9'd7);
    add_phase(150, 9'($urandom_range(1, 511)), 9'($urandom_range(0, 511)));
    add_phase(130, 9'd2, 9'd256);
  end

  // driver
  int unsigned settle_cnt;
  always @(posedge clk) begin
    pend_t p;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      settle_cnt <= 0;
    end else begin
      if (start && !busy) begin
        p = pending_q.pop_front();
        predict_sample(p.req);
      end
      if (cfg_valid && cfg_ready) begin
        p = pending_q.pop_front();
        if (p.idx == CFG_WIDTH) width_reg = p.data;
        else height_reg = p.data;
      end
      p = pending_q.size() ? pending_q[0] : '0;
      if (pending_q.size() && p.kind == K_DRAIN) begin
        // once drained and idle, wait until settle_cnt reaches SETTLE before going on
        if (colour_q.size() == 0 && !busy && !start) begin
          if (settle_cnt >= SETTLE) begin
            void'(pending_q.pop_front());
            settle_cnt <= 0;
          end else settle_cnt <= settle_cnt + 1;
        end
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending_q.size() && p.kind == K_CFG) begin
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= p.idx;
        cfg_data <= p.data;
      end else if (pending_q.size() && (!start || !busy)) begin
        cfg_valid <= 1'b0;
        if (!idle_off && $urandom_range(0, 99) < 16) start <= 1'b0;
        else begin
          start <= 1'b1;
          in_func <= p.req.func;
          in_write_x <= p.req.wx;
          in_write_y <= p.req.wy;
          in_write_color <= p.req.colour;
          in_coord_u <= p.req.u;
          in_coord_v <= p.req.v;
        end
      end else if (!pending_q.size()) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end
    end
  end

  // monitor: every strobed colour must match the oldest prediction
  always @(posedge clk) begin
    logic [15:0] exp_c;
    if (rst_n && out_valid) begin
      if (colour_q.size() == 0) begin
        $error("sample_color: unexpected result %h", out_sample_color);
        errors++;
      end else begin
        exp_c = colour_q.pop_front();
        if (out_sample_color !== exp_c) begin
          $error("sample_color: expected %h actual %h", exp_c, out_sample_color);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned k;
    errors = 0;
    cycles = 0;
    idle_off = 1'b0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    for (k = 0; k < StoreDepth; k++) texels[k] = 16'h0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_func = '0;
    in_write_x = '0;
    in_write_y = '0;
    in_write_color = '0;
    in_coord_u = '0;
    in_coord_v = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // a stretch in the middle without any sender gaps
    fork
      begin
        wait (pending_q.size() < 600);
        idle_off = 1'b1;
        wait (pending_q.size() < 400);
        idle_off = 1'b0;
      end
    join_none
    while (pending_q.size() || start || colour_q.size()) begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[texture_sampler_wrap_bilinear] ERROR");
        $finish;
      end
    end
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && colour_q.size() == 0) begin
      $display("[texture_sampler_wrap_bilinear] OK");
    end else begin
      $display("[texture_sampler_wrap_bilinear] ERROR");
    end
    $finish;
  end
endmodule
